### rtl/wcsp_pkg.sv
// Shared types and constants for the WAV chunk stream parser.
// Used by wcsp_front, wcsp_queue and wav_chunk_stream_parser; no dependencies.
package wcsp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_CAPTURE_LEN = 32'd16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] KIND_AUDIO  = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_NOT_WAVE  = 2'd0;
  localparam logic [1:0] ERR_MISSING   = 2'd1;
  localparam logic [1:0] ERR_SHORT_FMT = 2'd2;

  localparam logic REG_MUTE = 1'b0;

  typedef enum logic [5:0] {
    PH_RIFF  = 6'b000001,
    PH_CHUNK = 6'b000010,
    PH_FMT   = 6'b000100,
    PH_SKIP  = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  audio_byte;
    logic        is_last;
    logic        mono;
    logic        eight_bit;
    logic [31:0] pcm_rate;
    logic [1:0]  error_code;
  } result_t;

endpackage

### rtl/wav_chunk_stream_parser.sv
// Parses a RIFF/WAVE byte stream at one byte per clock: the front end handles each
// accepted byte in the cycle it is taken, and its result, if any, enters a four-entry
// result queue and is visible on the result ports from the next cycle. full rises only
// when four results wait unpopped; with pop kept high the block sustains one byte per
// cycle. Setting mute drops all results while parsing continues.
// Depends on wcsp_pkg, wcsp_front and wcsp_queue.
module wav_chunk_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_file_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  audio_byte_o,
  output logic        is_last_o,
  output logic        mono_o,
  output logic        eight_bit_o,
  output logic [31:0] pcm_rate_o,
  output logic [1:0]  error_code_o
);

  logic mute_q;
  logic in_valid;
  logic res_valid;
  wcsp_pkg::result_t res, head;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == wcsp_pkg::REG_MUTE) ? {31'd0, mute_q} : 32'd0;
  assign in_valid = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mute_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == wcsp_pkg::REG_MUTE) begin
      mute_q <= pwdata[0];
    end
  end

  wcsp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_byte_i     (in_byte_i),
    .end_of_file_i (end_of_file_i),
    .mute_i        (mute_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  wcsp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_valid),
    .wdata_i (res),
    .rd_i    (pop),
    .rdata_o (head),
    .full_o  (full),
    .empty_o (empty)
  );

  assign kind_o        = head.kind;
  assign audio_byte_o  = head.audio_byte;
  assign is_last_o     = head.is_last;
  assign mono_o        = head.mono;
  assign eight_bit_o   = head.eight_bit;
  assign pcm_rate_o    = head.pcm_rate;
  assign error_code_o  = head.error_code;

endmodule

### rtl/wcsp_front.sv
// Front end: parses the byte stream and classifies each byte into zero or one result.
// Depends on wcsp_pkg.
module wcsp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  input  logic              end_of_file_i,
  input  logic              mute_i,
  output logic              res_valid_o,
  output wcsp_pkg::result_t res_o
);

  wcsp_pkg::phase_e phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic        fmt_seen_q, fmt_seen_d;
  logic [31:0] left_q, left_d;
  logic        emit;
  wcsp_pkg::result_t res;

  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    tag_d      = tag_q;
    len_d      = len_q;
    chan_d     = chan_q;
    rate_d     = rate_q;
    bits_d     = bits_q;
    fmt_seen_d = fmt_seen_q;
    left_d     = left_q;
    emit       = 1'b0;
    res        = '0;

    case (phase_q)
      wcsp_pkg::PH_RIFF: begin
        tag_d = {in_byte_i, tag_q[31:8]};
        if (idx_q == 4'd3 && tag_d != wcsp_pkg::TAG_RIFF) begin
          emit = 1'b1;
        end else if (idx_q == 4'd11) begin
          if (tag_d != wcsp_pkg::TAG_WAVE) begin
            emit = 1'b1;
          end else begin
            phase_d = wcsp_pkg::PH_CHUNK;
            idx_d   = '0;
          end
        end else begin
          idx_d = idx_q + 4'd1;
          if (end_of_file_i) begin
            emit = 1'b1;
          end
        end
        if (emit) begin
          res.kind       = wcsp_pkg::KIND_ERROR;
          res.error_code = wcsp_pkg::ERR_NOT_WAVE;
        end
      end
      wcsp_pkg::PH_CHUNK: begin
        if (idx_q[2]) begin
          len_d = {in_byte_i, len_q[31:8]};
        end else begin
          tag_d = {in_byte_i, tag_q[31:8]};
        end
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd7) begin
          idx_d = '0;
          if (tag_q == wcsp_pkg::TAG_FMT) begin
            if (len_d < wcsp_pkg::FMT_CAPTURE_LEN) begin
              emit           = 1'b1;
              res.kind       = wcsp_pkg::KIND_ERROR;
              res.error_code = wcsp_pkg::ERR_SHORT_FMT;
            end else begin
              phase_d = wcsp_pkg::PH_FMT;
            end
          end else if (tag_q == wcsp_pkg::TAG_DATA) begin
            emit = 1'b1;
            if (!fmt_seen_q) begin
              res.kind       = wcsp_pkg::KIND_ERROR;
              res.error_code = wcsp_pkg::ERR_MISSING;
            end else begin
              left_d          = len_d;
              phase_d         = (len_d == '0 || end_of_file_i) ? wcsp_pkg::PH_DONE
                                                               : wcsp_pkg::PH_DATA;
              res.kind        = wcsp_pkg::KIND_REPORT;
              res.is_last     = (len_d == '0) || end_of_file_i;
              res.mono        = (chan_q == 16'd1);
              res.eight_bit   = (bits_q == 16'd8);
              res.pcm_rate    = rate_q;
            end
          end else begin
            phase_d = (len_d == '0) ? wcsp_pkg::PH_CHUNK : wcsp_pkg::PH_SKIP;
          end
        end
      end
      wcsp_pkg::PH_FMT: begin
        case (idx_q)
          4'd2:                   chan_d = {chan_q[15:8], in_byte_i};
          4'd3:                   chan_d = {in_byte_i, chan_q[7:0]};
          4'd4, 4'd5, 4'd6, 4'd7: rate_d = {in_byte_i, rate_q[31:8]};
          4'd14:                  bits_d = {bits_q[15:8], in_byte_i};
          4'd15:                  bits_d = {in_byte_i, bits_q[7:0]};
          default:                ;
        endcase
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd15) begin
          fmt_seen_d = 1'b1;
          idx_d      = '0;
          len_d      = len_q - wcsp_pkg::FMT_CAPTURE_LEN;
          phase_d    = (len_d == '0) ? wcsp_pkg::PH_CHUNK : wcsp_pkg::PH_SKIP;
        end
      end
      wcsp_pkg::PH_SKIP: begin
        if (len_q != '0) begin
          len_d = len_q - 32'd1;
        end
        if (len_d == '0) begin
          phase_d = wcsp_pkg::PH_CHUNK;
          idx_d   = '0;
        end
      end
      wcsp_pkg::PH_DATA: begin
        if (left_q != '0) begin
          left_d = left_q - 32'd1;
        end
        emit           = 1'b1;
        res.kind       = wcsp_pkg::KIND_AUDIO;
        res.audio_byte = in_byte_i;
        res.is_last    = (left_d == '0) || end_of_file_i;
        if (res.is_last) begin
          phase_d = wcsp_pkg::PH_DONE;
        end
      end
      default: ;
    endcase

    // Close the stream on an error or on end of file.
    if (emit && res.kind == wcsp_pkg::KIND_ERROR) begin
      phase_d = wcsp_pkg::PH_DONE;
    end else if (end_of_file_i && phase_q != wcsp_pkg::PH_DONE) begin
      if (!emit && phase_d != wcsp_pkg::PH_DONE) begin
        emit           = 1'b1;
        res            = '0;
        res.kind       = wcsp_pkg::KIND_ERROR;
        res.error_code = wcsp_pkg::ERR_MISSING;
      end
      phase_d = wcsp_pkg::PH_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= wcsp_pkg::PH_RIFF;
      idx_q      <= '0;
      tag_q      <= '0;
      len_q      <= '0;
      chan_q     <= '0;
      rate_q     <= '0;
      bits_q     <= '0;
      fmt_seen_q <= 1'b0;
      left_q     <= '0;
    end else if (in_valid_i) begin
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      tag_q      <= tag_d;
      len_q      <= len_d;
      chan_q     <= chan_d;
      rate_q     <= rate_d;
      bits_q     <= bits_d;
      fmt_seen_q <= fmt_seen_d;
      left_q     <= left_d;
    end
  end

  assign res_valid_o = in_valid_i && emit && !mute_i;
  assign res_o       = res;

endmodule

### rtl/wcsp_queue.sv
// Back end: short result queue that holds items until the consumer pops them.
// Depends on wcsp_pkg.
module wcsp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  wcsp_pkg::result_t wdata_i,
  input  logic              rd_i,
  output wcsp_pkg::result_t rdata_o,
  output logic              full_o,
  output logic              empty_o
);

  wcsp_pkg::result_t mem_q [wcsp_pkg::QUEUE_DEPTH];
  logic [wcsp_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [wcsp_pkg::QUEUE_AW:0]   count_q, count_d;
  logic do_wr, do_rd;

  assign full_o  = (count_q == (wcsp_pkg::QUEUE_AW+1)'(wcsp_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({do_wr, do_rd})
      2'b10:   count_d = count_q + (wcsp_pkg::QUEUE_AW+1)'(1);
      2'b01:   count_d = count_q - (wcsp_pkg::QUEUE_AW+1)'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + (wcsp_pkg::QUEUE_AW)'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + (wcsp_pkg::QUEUE_AW)'(1);
      end
      count_q <= count_d;
    end
  end

endmodule
